// ----- design/ost_pkg.sv -----
package ost_pkg;

  // Raw converter full scale and scaling factors
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned TEMP_W     = 9;
  localparam int unsigned SETP_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [12:0] RAW_FULL    = 13'd4095;
  localparam logic [11:0] SHORT_LIMIT = 12'd4080;
  localparam logic [8:0]  TEMP_SCALE  = 9'd330;
  localparam logic [5:0]  SETP_SCALE  = 6'd60;
  localparam logic [6:0]  SETP_BASE   = 7'd20;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_HEATING = 2'd1,
    MODE_COOLING = 2'd2,
    MODE_ALARM   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ALARM_OK    = 3'd0,
    ALARM_OPEN  = 3'd1,
    ALARM_SHORT = 3'd2,
    ALARM_OVER  = 3'd3,
    ALARM_UNDER = 3'd4,
    ALARM_RISE  = 3'd5,
    ALARM_FALL  = 3'd6
  } alarm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_THRESHOLD  = 3'd0,
    CFG_HYSTERESIS_BAND   = 3'd1,
    CFG_WARN_MARGIN       = 3'd2,
    CFG_RISE_LIMIT        = 3'd3,
    CFG_FALL_LIMIT        = 3'd4,
    CFG_OVERHEAT_LIMIT    = 3'd5,
    CFG_RESTART_LIMIT     = 3'd6,
    CFG_OPEN_SENSOR_LIMIT = 3'd7
  } cfg_idx_t;

endpackage

// ----- design/ost_ifs.sv -----
interface ost_in_if;
  logic                        valid;
  logic                        ready;
  logic [ost_pkg::RAW_W-1:0]   sensor_raw;
  logic [ost_pkg::RAW_W-1:0]   setpoint_raw;
  logic [ost_pkg::RAW_W-1:0]   enable_raw;
  logic                        clear_request;

  modport source (output valid, sensor_raw, setpoint_raw, enable_raw, clear_request,
                  input ready);
  modport sink (input valid, sensor_raw, setpoint_raw, enable_raw, clear_request,
                output ready);
endinterface

interface ost_out_if;
  logic                        valid;
  logic                        ready;
  logic                        heater;
  logic                        lamp;
  logic                        buzzer;
  ost_pkg::mode_t              mode;
  ost_pkg::alarm_t             alarm;
  logic [ost_pkg::TEMP_W-1:0]  temperature;
  logic [ost_pkg::SETP_W-1:0]  setpoint;
  logic                        cleared;

  modport source (output valid, heater, lamp, buzzer, mode, alarm, temperature, setpoint,
                  cleared, input ready);
  modport sink (input valid, heater, lamp, buzzer, mode, alarm, temperature, setpoint,
                cleared, output ready);
endinterface

interface ost_cfg_if;
  logic                            valid;
  logic                            ready;
  ost_pkg::cfg_idx_t               index;
  logic [ost_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/oven_safety_thermostat_core.sv -----
// Pipeline: an accepted sample word is captured in the input register, then moves to
// the result register once the result side is free. Throughput: one sample word per cycle
// while the result side does not stall; scaling sits before the input register and
// detection, history and heater control sit between input and result registers.
// Reset (rst_n, synchronous, active low) restores register defaults, clears lockout,
// heater, buzzer phase and history fill; history entries themselves are not cleared.
module oven_safety_thermostat_core #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  ost_in_if.sink        in_chan,
  ost_out_if.source     out_chan,
  ost_cfg_if.sink       cfg_chan
);

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

  // Configuration registers
  logic [11:0] enable_threshold_r;
  logic [4:0]  hysteresis_band_r;
  logic [5:0]  warn_margin_r;
  logic [8:0]  rise_limit_r;
  logic [8:0]  fall_limit_r;
  logic [8:0]  overheat_limit_r;
  logic [8:0]  restart_limit_r;
  logic [11:0] open_sensor_limit_r;

  assign cfg_chan.ready = 1'b1;

  // Take a register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_threshold_r  <= 12'd200;
      hysteresis_band_r   <= 5'd2;
      warn_margin_r       <= 6'd5;
      rise_limit_r        <= 9'd30;
      fall_limit_r        <= 9'd50;
      overheat_limit_r    <= 9'd300;
      restart_limit_r     <= 9'd250;
      open_sensor_limit_r <= 12'd10;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        ost_pkg::CFG_ENABLE_THRESHOLD:  enable_threshold_r  <= cfg_chan.data;
        ost_pkg::CFG_HYSTERESIS_BAND:   hysteresis_band_r   <= cfg_chan.data[4:0];
        ost_pkg::CFG_WARN_MARGIN:       warn_margin_r       <= cfg_chan.data[5:0];
        ost_pkg::CFG_RISE_LIMIT:        rise_limit_r        <= cfg_chan.data[8:0];
        ost_pkg::CFG_FALL_LIMIT:        fall_limit_r        <= cfg_chan.data[8:0];
        ost_pkg::CFG_OVERHEAT_LIMIT:    overheat_limit_r    <= cfg_chan.data[8:0];
        ost_pkg::CFG_RESTART_LIMIT:     restart_limit_r     <= cfg_chan.data[8:0];
        ost_pkg::CFG_OPEN_SENSOR_LIMIT: open_sensor_limit_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Scale the raw readings: x/4095 as x>>12 plus one correction step
  logic [20:0] temp_prod;
  logic [17:0] setp_prod;
  logic [12:0] temp_rem;
  logic [12:0] setp_rem;
  logic [8:0]  temp_scaled;
  logic [6:0]  setp_scaled;

  always_comb begin
    temp_prod   = 21'(in_chan.sensor_raw) * 21'(ost_pkg::TEMP_SCALE);
    setp_prod   = 18'(in_chan.setpoint_raw) * 18'(ost_pkg::SETP_SCALE);
    temp_rem    = {1'b0, temp_prod[11:0]} + 13'(temp_prod[20:12]);
    setp_rem    = {1'b0, setp_prod[11:0]} + 13'(setp_prod[17:12]);
    temp_scaled = temp_prod[20:12] + 9'(temp_rem >= ost_pkg::RAW_FULL);
    setp_scaled = ost_pkg::SETP_BASE + 7'(setp_prod[17:12])
                  + 7'(setp_rem >= ost_pkg::RAW_FULL);
  end

  // Input register and result register handshake
  logic        s1_v_r;
  logic [11:0] s1_sraw_r;
  logic [11:0] s1_eraw_r;
  logic [8:0]  s1_temp_r;
  logic [6:0]  s1_setp_r;
  logic        s1_clear_r;
  logic        out_v_r;
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;

  assign out_free      = !out_v_r || out_chan.ready;
  assign s1_fire       = s1_v_r && out_free;
  assign in_chan.ready = !s1_v_r || out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sraw_r  <= in_chan.sensor_raw;
      s1_eraw_r  <= in_chan.enable_raw;
      s1_temp_r  <= temp_scaled;
      s1_setp_r  <= setp_scaled;
      s1_clear_r <= in_chan.clear_request;
    end
  end

  // Control state
  logic [8:0]        hist_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              full_r, full_nxt;
  logic              lockout_r, lockout_nxt;
  ost_pkg::alarm_t   latched_r, latched_nxt;
  logic              heat_r, heat_nxt;
  logic              phase_r, phase_nxt;

  // Per-sample result
  logic              sensor_bad;
  logic              hist_wr;
  ost_pkg::alarm_t   found;
  logic [8:0]        prior_temp;
  logic              rise_hit;
  logic              fall_hit;
  logic              active;
  logic [7:0]        setp_lo;
  logic [7:0]        setp_hi;
  logic [7:0]        setp_warn;
  logic              heater_o, lamp_o, buzzer_o, cleared_o;
  ost_pkg::mode_t    mode_o;
  ost_pkg::alarm_t   alarm_o;

  assign prior_temp = hist_r[slot_r];

  always_comb begin
    sensor_bad = (s1_sraw_r < open_sensor_limit_r) || (s1_sraw_r > ost_pkg::SHORT_LIMIT);
    rise_hit   = {1'b0, s1_temp_r} > ({1'b0, prior_temp} + {1'b0, rise_limit_r});
    fall_hit   = {1'b0, prior_temp} > ({1'b0, s1_temp_r} + {1'b0, fall_limit_r});
    active     = s1_eraw_r > enable_threshold_r;
    setp_lo    = {1'b0, s1_setp_r};
    setp_hi    = {1'b0, s1_setp_r} + 8'(hysteresis_band_r);
    setp_warn  = {1'b0, s1_setp_r} + 8'(warn_margin_r);

    slot_nxt    = slot_r;
    fill_nxt    = fill_r;
    full_nxt    = full_r;
    lockout_nxt = lockout_r;
    latched_nxt = latched_r;
    heat_nxt    = heat_r;
    phase_nxt   = phase_r;
    hist_wr     = 1'b0;
    found       = ost_pkg::ALARM_OK;

    // Detect in priority order; history advances only past the limit checks
    priority if (s1_sraw_r < open_sensor_limit_r) begin
      found = ost_pkg::ALARM_OPEN;
    end else if (s1_sraw_r > ost_pkg::SHORT_LIMIT) begin
      found = ost_pkg::ALARM_SHORT;
    end else if (s1_temp_r > overheat_limit_r) begin
      found = ost_pkg::ALARM_OVER;
    end else begin
      hist_wr  = 1'b1;
      slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
      if (!full_r) begin
        if (fill_r < FULL_CNT) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (fill_nxt >= FULL_CNT) begin
          full_nxt = 1'b1;
        end
      end else if (rise_hit) begin
        found = ost_pkg::ALARM_RISE;
      end else if (fall_hit) begin
        found = ost_pkg::ALARM_FALL;
      end
    end

    // Latch a new alarm
    if (found != ost_pkg::ALARM_OK) begin
      latched_nxt = found;
      lockout_nxt = 1'b1;
      heat_nxt    = 1'b0;
    end

    heater_o  = 1'b0;
    lamp_o    = 1'b0;
    buzzer_o  = 1'b0;
    cleared_o = 1'b0;
    mode_o    = ost_pkg::MODE_STANDBY;
    alarm_o   = ost_pkg::ALARM_OK;

    if (lockout_nxt) begin
      // Locked out: toggle the buzzer, release on a sane clear request
      mode_o    = ost_pkg::MODE_ALARM;
      phase_nxt = !phase_r;
      buzzer_o  = phase_nxt;
      alarm_o   = latched_nxt;
      if (s1_clear_r && !sensor_bad && (s1_temp_r <= restart_limit_r)) begin
        lockout_nxt = 1'b0;
        latched_nxt = ost_pkg::ALARM_OK;
        heat_nxt    = 1'b0;
        buzzer_o    = 1'b0;
        full_nxt    = 1'b0;
        slot_nxt    = '0;
        fill_nxt    = '0;
        cleared_o   = 1'b1;
      end
    end else if (active) begin
      // Hysteresis control around the setpoint
      lamp_o = 1'b1;
      if ({1'b0, s1_temp_r} + 10'(hysteresis_band_r) < {2'b0, setp_lo}) begin
        heat_nxt = 1'b1;
      end else if ({1'b0, s1_temp_r} > {2'b0, setp_hi}) begin
        heat_nxt = 1'b0;
      end
      if (heat_nxt) begin
        heater_o = 1'b1;
        mode_o   = ost_pkg::MODE_HEATING;
      end else begin
        mode_o   = ost_pkg::MODE_COOLING;
        buzzer_o = {1'b0, s1_temp_r} > {2'b0, setp_warn};
      end
    end else begin
      heat_nxt = 1'b0;
    end
  end

  // Advance control state on each processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      fill_r    <= '0;
      full_r    <= 1'b0;
      lockout_r <= 1'b0;
      latched_r <= ost_pkg::ALARM_OK;
      heat_r    <= 1'b0;
      phase_r   <= 1'b0;
    end else if (s1_fire) begin
      slot_r    <= slot_nxt;
      fill_r    <= fill_nxt;
      full_r    <= full_nxt;
      lockout_r <= lockout_nxt;
      latched_r <= latched_nxt;
      heat_r    <= heat_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // Write the temperature history
  always_ff @(posedge clk) begin
    if (s1_fire && hist_wr) begin
      hist_r[slot_r] <= s1_temp_r;
    end
  end

  // Result register
  logic            out_heater_r, out_lamp_r, out_buzzer_r, out_cleared_r;
  ost_pkg::mode_t  out_mode_r;
  ost_pkg::alarm_t out_alarm_r;
  logic [8:0]      out_temp_r;
  logic [6:0]      out_setp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_heater_r  <= heater_o;
      out_lamp_r    <= lamp_o;
      out_buzzer_r  <= buzzer_o;
      out_cleared_r <= cleared_o;
      out_mode_r    <= mode_o;
      out_alarm_r   <= alarm_o;
      out_temp_r    <= s1_temp_r;
      out_setp_r    <= s1_setp_r;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.heater      = out_heater_r;
  assign out_chan.lamp        = out_lamp_r;
  assign out_chan.buzzer      = out_buzzer_r;
  assign out_chan.mode        = out_mode_r;
  assign out_chan.alarm       = out_alarm_r;
  assign out_chan.temperature = out_temp_r;
  assign out_chan.setpoint    = out_setp_r;
  assign out_chan.cleared     = out_cleared_r;

endmodule

// ----- design/ost_checker.sv -----
module ost_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic            heater,
  input logic            lamp,
  input logic            buzzer,
  input ost_pkg::mode_t  mode,
  input ost_pkg::alarm_t alarm,
  input logic            cleared
);

  // A held result word stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(alarm)
      && $stable(heater) && $stable(buzzer))
    else $error("result word changed while stalled");

  // Alarm mode always carries a code and drives heater and lamp off
  a_alarm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode == ost_pkg::MODE_ALARM |->
      alarm != ost_pkg::ALARM_OK && !heater && !lamp)
    else $error("alarm mode without code or with drives on");

  // Outside lockout no alarm code and no release
  a_no_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode != ost_pkg::MODE_ALARM |-> alarm == ost_pkg::ALARM_OK && !cleared)
    else $error("alarm code or release outside lockout");

  // Heater runs only in heating mode
  a_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && heater |-> mode == ost_pkg::MODE_HEATING && lamp)
    else $error("heater on outside heating mode");

  // A release silences the buzzer
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cleared |-> !buzzer)
    else $error("buzzer on at release");

endmodule

bind oven_safety_thermostat_core ost_checker u_ost_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .heater    (out_chan.heater),
  .lamp      (out_chan.lamp),
  .buzzer    (out_chan.buzzer),
  .mode      (out_chan.mode),
  .alarm     (out_chan.alarm),
  .cleared   (out_chan.cleared)
);

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 5;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REG_W [8]   = '{12, 5, 6, 9, 9, 9, 9, 12};

  typedef struct {
    logic [ost_pkg::RAW_W-1:0] sensor_raw;
    logic [ost_pkg::RAW_W-1:0] setpoint_raw;
    logic [ost_pkg::RAW_W-1:0] enable_raw;
    logic                      clear_request;
  } sample_t;

  typedef struct {
    logic                       heater;
    logic                       lamp;
    logic                       buzzer;
    ost_pkg::mode_t             mode;
    ost_pkg::alarm_t            alarm;
    logic [ost_pkg::TEMP_W-1:0] temperature;
    logic [ost_pkg::SETP_W-1:0] setpoint;
    logic                       cleared;
  } reading_t;

  // Thermostat predictor plus the queue of readings still owed by the block
  class thermostat_board;
    int enable_thr, hyst, warn, rise_lim, fall_lim, over_lim, restart_lim, open_lim;
    int history [DEPTH];
    int slot, fill;
    bit full, lockout, heat_state, buzz_phase;
    ost_pkg::alarm_t held;
    reading_t pending_readings [$];
    int errors;

    function new();
      enable_thr = 200; hyst = 2; warn = 5; rise_lim = 30;
      fall_lim = 50; over_lim = 300; restart_lim = 250; open_lim = 10;
      foreach (history[i]) history[i] = 0;
      slot = 0; fill = 0; full = 0; lockout = 0;
      heat_state = 0; buzz_phase = 0; held = ost_pkg::ALARM_OK; errors = 0;
    endfunction

    // Mask the written word to the register's width
    function void apply_setting(ost_pkg::cfg_idx_t idx,
                                logic [ost_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ost_pkg::CFG_ENABLE_THRESHOLD:  enable_thr  = data[11:0];
        ost_pkg::CFG_HYSTERESIS_BAND:   hyst        = data[4:0];
        ost_pkg::CFG_WARN_MARGIN:       warn        = data[5:0];
        ost_pkg::CFG_RISE_LIMIT:        rise_lim    = data[8:0];
        ost_pkg::CFG_FALL_LIMIT:        fall_lim    = data[8:0];
        ost_pkg::CFG_OVERHEAT_LIMIT:    over_lim    = data[8:0];
        ost_pkg::CFG_RESTART_LIMIT:     restart_lim = data[8:0];
        ost_pkg::CFG_OPEN_SENSOR_LIMIT: open_lim    = data[11:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    function void predict_sample(sample_t s);
      int sraw, praw, eraw, t, sp, old, diff;
      bit active;
      ost_pkg::alarm_t found;
      reading_t r;
      sraw = s.sensor_raw;
      praw = s.setpoint_raw;
      eraw = s.enable_raw;
      t = sraw * 330 / 4095;
      sp = 20 + praw * 60 / 4095;
      active = eraw > enable_thr;
      r.heater = 1'b0; r.lamp = 1'b0; r.buzzer = 1'b0; r.cleared = 1'b0;
      r.mode = ost_pkg::MODE_STANDBY; r.alarm = ost_pkg::ALARM_OK;

      // Sensor and limit checks in priority order, then the rate check
      found = ost_pkg::ALARM_OK;
      if (sraw < open_lim) begin
        found = ost_pkg::ALARM_OPEN;
      end else if (sraw > ost_pkg::SHORT_LIMIT) begin
        found = ost_pkg::ALARM_SHORT;
      end else if (t > over_lim) begin
        found = ost_pkg::ALARM_OVER;
      end else if (t < -10) begin
        // scaled readings are never negative, so underheat stays dormant
        found = ost_pkg::ALARM_UNDER;
      end else begin
        old = history[slot];
        history[slot] = t;
        slot = (slot + 1) % DEPTH;
        if (!full) begin
          if (fill < DEPTH) fill++;
          if (fill >= DEPTH) full = 1'b1;
        end else begin
          diff = t - old;
          if (diff > rise_lim) found = ost_pkg::ALARM_RISE;
          else if (diff < -fall_lim) found = ost_pkg::ALARM_FALL;
        end
      end

      // Latch any new alarm, replacing the held one
      if (found != ost_pkg::ALARM_OK) begin
        held = found;
        lockout = 1'b1;
        heat_state = 1'b0;
      end

      if (lockout) begin
        r.mode = ost_pkg::MODE_ALARM;
        buzz_phase = !buzz_phase;
        r.buzzer = buzz_phase;
        r.alarm = held;
        // Release only with a sane sensor at or below the restart limit
        if (s.clear_request && sraw >= open_lim && sraw <= ost_pkg::SHORT_LIMIT &&
            t <= restart_lim) begin
          lockout = 1'b0;
          held = ost_pkg::ALARM_OK;
          heat_state = 1'b0;
          r.buzzer = 1'b0;
          full = 1'b0;
          slot = 0;
          fill = 0;
          r.cleared = 1'b1;
        end
      end else if (active) begin
        r.lamp = 1'b1;
        if (t < sp - hyst) heat_state = 1'b1;
        else if (t > sp + hyst) heat_state = 1'b0;
        if (heat_state) begin
          r.heater = 1'b1;
          r.mode = ost_pkg::MODE_HEATING;
        end else begin
          r.mode = ost_pkg::MODE_COOLING;
          r.buzzer = t > sp + warn;
        end
      end else begin
        heat_state = 1'b0;
      end

      r.temperature = t[8:0];
      r.setpoint = sp[6:0];
      pending_readings.push_back(r);
    endfunction

    function void check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $error("result word with no sample pending");
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      check_field("heater", want.heater, got.heater);
      check_field("lamp", want.lamp, got.lamp);
      check_field("buzzer", want.buzzer, got.buzzer);
      check_field("mode", want.mode, got.mode);
      check_field("alarm", want.alarm, got.alarm);
      check_field("temperature", want.temperature, got.temperature);
      check_field("setpoint", want.setpoint, got.setpoint);
      check_field("cleared", want.cleared, got.cleared);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  thermostat_board board = new();

  int drift_raw = 500;
  int knob_raw = 2048;
  bit calm = 1'b0;
  bit held_off = 1'b0;
  int results_seen = 0;
  int cycle_count = 0;

  ost_in_if  in_bus ();
  ost_out_if out_bus ();
  ost_cfg_if cfg_bus ();

  oven_safety_thermostat_core #(.HISTORY_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #10 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check every accepted result word against the oldest prediction
  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.heater = out_bus.heater;
      got.lamp = out_bus.lamp;
      got.buzzer = out_bus.buzzer;
      got.mode = out_bus.mode;
      got.alarm = out_bus.alarm;
      got.temperature = out_bus.temperature;
      got.setpoint = out_bus.setpoint;
      got.cleared = out_bus.cleared;
      board.check_reading(got);
      results_seen <= results_seen + 1;
    end
  end

  // Stall the result side at random; hold off once for a long stretch
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 200) begin
        held_off = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (150) @(negedge clk);
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  function automatic int raw_for(int deg);
    return (deg * 4095 + 329) / 330;
  endfunction

  // Offer one sample word after an optional gap; note it once accepted
  task automatic send_sample(int sensor, int knob, int enable, bit clear);
    sample_t s;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    s.sensor_raw = 12'(sensor);
    s.setpoint_raw = 12'(knob);
    s.enable_raw = 12'(enable);
    s.clear_request = clear;
    in_bus.valid <= 1'b1;
    in_bus.sensor_raw <= s.sensor_raw;
    in_bus.setpoint_raw <= s.setpoint_raw;
    in_bus.enable_raw <= s.enable_raw;
    in_bus.clear_request <= s.clear_request;
    do @(posedge clk); while (!in_bus.ready);
    board.predict_sample(s);
    @(negedge clk);
  endtask

  // Drop valid and let every owed result drain
  task automatic wait_for_quiet();
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_registers(input logic [ost_pkg::CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= ost_pkg::cfg_idx_t'(i);
      cfg_bus.data <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
      board.apply_setting(ost_pkg::cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_bus.valid <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // Mostly a sensor drifting with the heater, with jumps, noise and extremes
  task automatic run_samples(int count);
    int roll, lo, enable;
    bit clear;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (board.lockout && $urandom_range(0, 99) < 30) begin
        drift_raw = $urandom_range(250, 1000);
      end else if (roll < 78) begin
        drift_raw += (board.heat_state ? 10 : -10) + int'($urandom_range(0, 40)) - 20;
      end else if (roll < 86) begin
        if ($urandom_range(0, 1)) drift_raw += int'($urandom_range(200, 1500));
        else drift_raw -= int'($urandom_range(200, 1500));
      end else if (roll < 93) begin
        drift_raw = $urandom_range(0, 4095);
      end else begin
        case ($urandom_range(0, 4))
          0: drift_raw = 0;
          1: drift_raw = 4095;
          2: drift_raw = ost_pkg::SHORT_LIMIT;
          3: drift_raw = ost_pkg::SHORT_LIMIT + 1;
          default: drift_raw = (board.open_lim > 0) ? board.open_lim - 1 : 0;
        endcase
      end
      if (drift_raw < 0) drift_raw = 0;
      if (drift_raw > 4095) drift_raw = 4095;

      if ($urandom_range(0, 99) < 6) knob_raw = $urandom_range(0, 4095);
      lo = (board.enable_thr < 4095) ? board.enable_thr + 1 : 4095;
      enable = ($urandom_range(0, 99) < 85) ? $urandom_range(lo, 4095) : $urandom_range(0, 4095);
      clear = board.lockout ? ($urandom_range(0, 99) < 35) : ($urandom_range(0, 99) < 4);
      send_sample(drift_raw, knob_raw, enable, clear);
    end
  endtask

  initial begin
    logic [ost_pkg::CFG_DATA_W-1:0] vals [8];

    // Drive every input to a known value before the first edge
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sensor_raw = '0;
    in_bus.setpoint_raw = '0;
    in_bus.enable_raw = '0;
    in_bus.clear_request = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = ost_pkg::CFG_ENABLE_THRESHOLD;
    cfg_bus.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Standby, including the enable knob right at the threshold
    send_sample(raw_for(40), 0, 0, 1'b0);
    send_sample(raw_for(40), 0, 200, 1'b0);
    // Heating, in-band hold, cooling, warning buzzer, back to heating
    send_sample(raw_for(40), 4095, 201, 1'b0);
    send_sample(raw_for(50), 2048, 4095, 1'b0);
    send_sample(raw_for(53), 2048, 4095, 1'b0);
    send_sample(raw_for(56), 2048, 4095, 1'b0);
    send_sample(raw_for(47), 2048, 4095, 1'b0);
    // Clear without a lockout is ignored
    send_sample(raw_for(48), 2048, 4095, 1'b1);
    // Rise alarm, a locked-out sample, then an accepted clear
    send_sample(raw_for(90), 2048, 4095, 1'b0);
    send_sample(raw_for(50), 2048, 4095, 1'b0);
    send_sample(raw_for(50), 2048, 4095, 1'b1);
    // Refill the history high, then drop fast for a fall alarm
    repeat (5) send_sample(raw_for(200), 2048, 4095, 1'b0);
    send_sample(raw_for(140), 2048, 4095, 1'b0);
    // Refused clears: too hot, open sensor, shorted sensor
    send_sample(raw_for(260), 2048, 4095, 1'b1);
    send_sample(0, 2048, 4095, 1'b1);
    send_sample(4095, 2048, 4095, 1'b1);
    // Short and overheat edges, open edge, clear at the open limit
    send_sample(ost_pkg::SHORT_LIMIT + 1, 4095, 4095, 1'b0);
    send_sample(ost_pkg::SHORT_LIMIT, 4095, 4095, 1'b0);
    send_sample(9, 0, 4095, 1'b0);
    send_sample(10, 0, 4095, 1'b1);
    send_sample(4095, 4095, 4095, 1'b0);
    run_samples(350);

    // All registers at their low extreme
    wait_for_quiet();
    program_registers('{default: 12'h000});
    run_samples(100);

    // All bits set, so every register saturates after masking
    wait_for_quiet();
    program_registers('{default: 12'hFFF});
    run_samples(80);

    // Permissive limits, widest bands, and no idling on either side
    wait_for_quiet();
    program_registers('{12'd0, 12'd31, 12'd63, 12'd511, 12'd511, 12'd511, 12'd511, 12'd0});
    calm = 1'b1;
    run_samples(300);
    calm = 1'b0;

    // Random settings with junk above each register's width
    for (int k = 0; k < 4; k++) begin
      wait_for_quiet();
      vals[0] = 12'($urandom_range(0, 1200));
      vals[1] = 12'($urandom_range(0, 31));
      vals[2] = 12'($urandom_range(0, 63));
      vals[3] = 12'($urandom_range(5, 80));
      vals[4] = 12'($urandom_range(5, 120));
      vals[5] = 12'($urandom_range(60, 511));
      vals[6] = 12'($urandom_range(30, 511));
      vals[7] = 12'($urandom_range(0, 400));
      for (int i = 0; i < 8; i++)
        vals[i] = vals[i] | (12'($urandom) & ~(12'hFFF >> (12 - REG_W[i])));
      program_registers(vals);
      run_samples(140);
    end

    wait_for_quiet();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- oven_safety_thermostat_core.f -----
design/ost_pkg.sv
design/ost_ifs.sv
design/oven_safety_thermostat_core.sv
design/ost_checker.sv
test/testbench.sv
